### rtl/hgnf_pkg.sv
// ----------------------------------------------------------------------------
// hgnf_pkg
// Shared types and codes for the grid neighbor finder: command codes, the
// tag that rides the distance pipeline, and one result word.
// ----------------------------------------------------------------------------
package hgnf_pkg;

    localparam int ID_BITS   = 20;
    localparam int QIDX_BITS = 10;
    localparam int FUNC_BITS = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_QUERY = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic               is_load;
        logic               skip;
        logic               is_end;
        logic [ID_BITS-1:0] id;
    } dist_tag_t;

    typedef struct packed {
        logic [ID_BITS-1:0] neighbor_id;
        logic               found;
        logic               last;
        logic               overflow;
        logic               bad_query;
    } result_t;

endpackage

### rtl/hgnf_cmd_queue.sv
// ----------------------------------------------------------------------------
// hgnf_cmd_queue
// Front end: accepts input words, drops unused function codes and queues
// load, query and clear commands for the back end.
// ----------------------------------------------------------------------------
module hgnf_cmd_queue #(
    parameter int COORD_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [hgnf_pkg::FUNC_BITS-1:0]      func,
    input  logic signed [COORD_BITS-1:0]        x_coord,
    input  logic signed [COORD_BITS-1:0]        y_coord,
    input  logic [hgnf_pkg::ID_BITS-1:0]        cell_id,
    input  logic [hgnf_pkg::QIDX_BITS-1:0]      query_index,
    output logic                                cmd_valid,
    input  logic                                cmd_pop,
    output logic [hgnf_pkg::FUNC_BITS-1:0]      cmd_func,
    output logic signed [COORD_BITS-1:0]        cmd_x,
    output logic signed [COORD_BITS-1:0]        cmd_y,
    output logic [hgnf_pkg::ID_BITS-1:0]        cmd_id,
    output logic [hgnf_pkg::QIDX_BITS-1:0]      cmd_qidx
);

    import hgnf_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [FUNC_BITS-1:0]         func_q [DEPTH];
    logic signed [COORD_BITS-1:0] x_q    [DEPTH];
    logic signed [COORD_BITS-1:0] y_q    [DEPTH];
    logic [ID_BITS-1:0]           id_q   [DEPTH];
    logic [QIDX_BITS-1:0]         qidx_q [DEPTH];

    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic            is_cmd;
    logic            push;
    logic            pop;

    always_comb
    begin
        case (func)
            FUNC_LOAD:  is_cmd = 1'b1;
            FUNC_QUERY: is_cmd = 1'b1;
            FUNC_CLEAR: is_cmd = 1'b1;
            default:    is_cmd = 1'b0;
        endcase
    end

    assign in_stall  = (cnt_reg == CNTW'(DEPTH));
    assign push      = in_valid && !in_stall && is_cmd;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_pop;

    assign cmd_func = func_q[rd_ptr_reg];
    assign cmd_x    = x_q[rd_ptr_reg];
    assign cmd_y    = y_q[rd_ptr_reg];
    assign cmd_id   = id_q[rd_ptr_reg];
    assign cmd_qidx = qidx_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            func_q[wr_ptr_reg] <= func;
            x_q[wr_ptr_reg]    <= x_coord;
            y_q[wr_ptr_reg]    <= y_coord;
            id_q[wr_ptr_reg]   <= cell_id;
            qidx_q[wr_ptr_reg] <= query_index;
        end
    end

endmodule

### rtl/hgnf_dist.sv
// ----------------------------------------------------------------------------
// hgnf_dist
// Three-stage squared distance pipeline: absolute differences, squares,
// sum. A tag travels alongside each pair of points.
// ----------------------------------------------------------------------------
module hgnf_dist #(
    parameter int COORD_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  hgnf_pkg::dist_tag_t           in_tag,
    input  logic signed [COORD_BITS-1:0]  x0,
    input  logic signed [COORD_BITS-1:0]  y0,
    input  logic signed [COORD_BITS-1:0]  x1,
    input  logic signed [COORD_BITS-1:0]  y1,
    output logic                          out_valid,
    output hgnf_pkg::dist_tag_t           out_tag,
    output logic [2*COORD_BITS+1:0]       out_dist
);

    import hgnf_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int SW = 2 * CB;
    localparam int DW = 2 * CB + 2;

    logic signed [CB:0] dx;
    logic signed [CB:0] dy;
    logic [CB-1:0]      ax_next;
    logic [CB-1:0]      ay_next;

    logic [2:0]         vld_reg;
    dist_tag_t          tag1_reg;
    dist_tag_t          tag2_reg;
    dist_tag_t          tag3_reg;
    logic [CB-1:0]      ax_reg;
    logic [CB-1:0]      ay_reg;
    logic [SW-1:0]      sqx_reg;
    logic [SW-1:0]      sqy_reg;
    logic [DW-1:0]      dist_reg;

    always_comb
    begin
        dx      = {x0[CB-1], x0} - {x1[CB-1], x1};
        dy      = {y0[CB-1], y0} - {y1[CB-1], y1};
        ax_next = dx[CB] ? CB'(-dx) : CB'(dx);
        ay_next = dy[CB] ? CB'(-dy) : CB'(dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= in_tag;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        tag2_reg <= tag1_reg;
        sqx_reg  <= SW'(ax_reg) * SW'(ax_reg);
        sqy_reg  <= SW'(ay_reg) * SW'(ay_reg);
        tag3_reg <= tag2_reg;
        dist_reg <= DW'(sqx_reg) + DW'(sqy_reg);
    end

    assign out_valid = vld_reg[2];
    assign out_tag   = tag3_reg;
    assign out_dist  = dist_reg;

endmodule

### rtl/hgnf_walker.sv
// ----------------------------------------------------------------------------
// hgnf_walker
// Back end: holds the point memory and spacing, executes load, clear and
// query commands, and walks the loaded points for a query.
// ----------------------------------------------------------------------------
module hgnf_walker #(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 6,
    parameter int COORD_BITS    = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_pop,
    input  logic [hgnf_pkg::FUNC_BITS-1:0]      cmd_func,
    input  logic signed [COORD_BITS-1:0]        cmd_x,
    input  logic signed [COORD_BITS-1:0]        cmd_y,
    input  logic [hgnf_pkg::ID_BITS-1:0]        cmd_id,
    input  logic [hgnf_pkg::QIDX_BITS-1:0]      cmd_qidx,
    input  logic                                out_empty,
    output logic                                push_valid,
    output hgnf_pkg::result_t                   push_data
);

    import hgnf_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int DW   = 2 * CB + 2;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CMPW = (CW > QIDX_BITS) ? CW : QIDX_BITS;
    localparam int EW   = 2 * CB + ID_BITS;
    localparam int FW   = $clog2(MAX_NEIGHBORS + 1);

    localparam logic [DW-1:0]   SP_ONES  = {DW{1'b1}};
    localparam logic [DW+3:0]   S9_RESET = ({4'b0000, SP_ONES} << 3) + {4'b0000, SP_ONES};

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_LOAD_WAIT = 3'd1;
    localparam logic [2:0] ST_QREAD     = 3'd2;
    localparam logic [2:0] ST_QWALK     = 3'd3;
    localparam logic [2:0] ST_QDRAIN    = 3'd4;
    localparam logic [2:0] ST_QFIN      = 3'd5;

    logic [EW-1:0] mem [MAX_POINTS];
    logic [EW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic signed [CB-1:0] rd_x;
    logic signed [CB-1:0] rd_y;
    logic [ID_BITS-1:0]   rd_id;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [DW-1:0]        sp_reg;
    logic [DW-1:0]        sp_next;
    logic [DW+3:0]        s9_reg;
    logic [DW+3:0]        s9_next;
    logic                 sp_valid_reg;
    logic                 sp_valid_next;
    logic                 rd_tag_valid_reg;
    logic                 rd_tag_valid_next;
    logic                 rd_tag_skip_reg;
    logic                 rd_tag_skip_next;
    logic                 rd_tag_end_reg;
    logic                 rd_tag_end_next;
    logic [FW-1:0]        found_cnt_reg;
    logic [FW-1:0]        found_cnt_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic signed [CB-1:0] p0x_reg;
    logic signed [CB-1:0] p0x_next;
    logic signed [CB-1:0] p0y_reg;
    logic signed [CB-1:0] p0y_next;
    logic signed [CB-1:0] qx_reg;
    logic signed [CB-1:0] qx_next;
    logic signed [CB-1:0] qy_reg;
    logic signed [CB-1:0] qy_next;
    logic [AW-1:0]        q_addr_reg;
    logic [AW-1:0]        q_addr_next;
    logic [AW-1:0]        walk_i_reg;
    logic [AW-1:0]        walk_i_next;
    logic [ID_BITS-1:0]   pend_id_reg;
    logic [ID_BITS-1:0]   pend_id_next;

    logic                 dist_in_valid;
    dist_tag_t            dist_in_tag;
    logic signed [CB-1:0] dist_x0;
    logic signed [CB-1:0] dist_y0;
    logic signed [CB-1:0] dist_x1;
    logic signed [CB-1:0] dist_y1;
    logic                 dist_out_valid;
    dist_tag_t            dist_out_tag;
    logic [DW-1:0]        dist_d;

    logic [DW+3:0]        four_d;
    logic [DW+3:0]        nine_d;
    logic                 hit;
    logic [CMPW-1:0]      q_cmp;
    logic                 bad;
    logic                 walk_last;

    assign rd_x  = rdata_reg[EW-1 -: CB];
    assign rd_y  = rdata_reg[ID_BITS+CB-1 -: CB];
    assign rd_id = rdata_reg[ID_BITS-1:0];

    assign wr_addr = count_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {cmd_x, cmd_y, cmd_id};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    hgnf_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dist_in_valid),
        .in_tag    (dist_in_tag),
        .x0        (dist_x0),
        .y0        (dist_y0),
        .x1        (dist_x1),
        .y1        (dist_y1),
        .out_valid (dist_out_valid),
        .out_tag   (dist_out_tag),
        .out_dist  (dist_d)
    );

    assign four_d    = {2'b00, dist_d, 2'b00};
    assign nine_d    = {4'b0000, dist_d} + {1'b0, dist_d, 3'b000};
    assign hit       = !dist_out_tag.skip && (four_d < s9_reg);
    assign q_cmp     = CMPW'(cmd_qidx);
    assign bad       = (count_reg < CW'(2)) || !sp_valid_reg || (q_cmp >= CMPW'(count_reg));
    assign walk_last = (CW'(walk_i_reg) == count_reg - CW'(1));

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        sp_next           = sp_reg;
        s9_next           = s9_reg;
        sp_valid_next     = sp_valid_reg;
        rd_tag_valid_next = 1'b0;
        rd_tag_skip_next  = rd_tag_skip_reg;
        rd_tag_end_next   = rd_tag_end_reg;
        found_cnt_next    = found_cnt_reg;
        ovf_next          = ovf_reg;
        p0x_next          = p0x_reg;
        p0y_next          = p0y_reg;
        qx_next           = qx_reg;
        qy_next           = qy_reg;
        q_addr_next       = q_addr_reg;
        walk_i_next       = walk_i_reg;
        pend_id_next      = pend_id_reg;

        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = walk_i_reg;
        push_valid = 1'b0;
        push_data  = '0;

        dist_in_valid      = rd_tag_valid_reg;
        dist_in_tag.is_load = 1'b0;
        dist_in_tag.skip   = rd_tag_skip_reg;
        dist_in_tag.is_end = rd_tag_end_reg;
        dist_in_tag.id     = rd_id;
        dist_x0            = qx_reg;
        dist_y0            = qy_reg;
        dist_x1            = rd_x;
        dist_y1            = rd_y;

        // spacing update from a load
        if (dist_out_valid && dist_out_tag.is_load)
        begin
            if (dist_d < sp_reg)
            begin
                sp_next = dist_d;
                s9_next = nine_d;
            end
            sp_valid_next = 1'b1;
        end

        // one neighbor held back so the final one can carry last
        if (dist_out_valid && !dist_out_tag.is_load && hit)
        begin
            if (found_cnt_reg == '0)
            begin
                pend_id_next   = dist_out_tag.id;
                found_cnt_next = FW'(1);
            end
            else if (found_cnt_reg < FW'(MAX_NEIGHBORS))
            begin
                push_valid            = 1'b1;
                push_data.neighbor_id = pend_id_reg;
                push_data.found       = 1'b1;
                pend_id_next          = dist_out_tag.id;
                found_cnt_next        = found_cnt_reg + FW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_func)
                        FUNC_LOAD:
                        begin
                            cmd_pop = 1'b1;
                            if (count_reg < CW'(MAX_POINTS))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (count_reg == '0)
                                begin
                                    p0x_next = cmd_x;
                                    p0y_next = cmd_y;
                                end
                                else
                                begin
                                    dist_in_valid       = 1'b1;
                                    dist_in_tag.is_load = 1'b1;
                                    dist_in_tag.skip    = 1'b0;
                                    dist_in_tag.is_end  = 1'b0;
                                    dist_in_tag.id      = cmd_id;
                                    dist_x0             = p0x_reg;
                                    dist_y0             = p0y_reg;
                                    dist_x1             = cmd_x;
                                    dist_y1             = cmd_y;
                                    state_next          = ST_LOAD_WAIT;
                                end
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (out_empty)
                            begin
                                cmd_pop = 1'b1;
                                if (bad)
                                begin
                                    push_valid          = 1'b1;
                                    push_data.last      = 1'b1;
                                    push_data.bad_query = 1'b1;
                                end
                                else
                                begin
                                    rd_en       = 1'b1;
                                    rd_addr     = AW'(q_cmp);
                                    q_addr_next = AW'(q_cmp);
                                    state_next  = ST_QREAD;
                                end
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            cmd_pop       = 1'b1;
                            count_next    = '0;
                            sp_next       = SP_ONES;
                            s9_next       = S9_RESET;
                            sp_valid_next = 1'b0;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_LOAD_WAIT:
            begin
                if (dist_out_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QREAD:
            begin
                qx_next        = rd_x;
                qy_next        = rd_y;
                found_cnt_next = '0;
                ovf_next       = 1'b0;
                walk_i_next    = '0;
                state_next     = ST_QWALK;
            end
            ST_QWALK:
            begin
                rd_en             = 1'b1;
                rd_addr           = walk_i_reg;
                rd_tag_valid_next = 1'b1;
                rd_tag_skip_next  = (walk_i_reg == q_addr_reg);
                rd_tag_end_next   = walk_last;
                if (walk_last)
                begin
                    state_next = ST_QDRAIN;
                end
                else
                begin
                    walk_i_next = walk_i_reg + AW'(1);
                end
            end
            ST_QDRAIN:
            begin
                if (dist_out_valid && dist_out_tag.is_end)
                begin
                    state_next = ST_QFIN;
                end
            end
            ST_QFIN:
            begin
                push_valid     = 1'b1;
                push_data.last = 1'b1;
                if (found_cnt_reg != '0)
                begin
                    push_data.neighbor_id = pend_id_reg;
                    push_data.found       = 1'b1;
                    push_data.overflow    = ovf_reg;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            sp_reg           <= SP_ONES;
            s9_reg           <= S9_RESET;
            sp_valid_reg     <= 1'b0;
            rd_tag_valid_reg <= 1'b0;
            found_cnt_reg    <= '0;
            ovf_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            sp_reg           <= sp_next;
            s9_reg           <= s9_next;
            sp_valid_reg     <= sp_valid_next;
            rd_tag_valid_reg <= rd_tag_valid_next;
            found_cnt_reg    <= found_cnt_next;
            ovf_reg          <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tag_skip_reg <= rd_tag_skip_next;
        rd_tag_end_reg  <= rd_tag_end_next;
        p0x_reg         <= p0x_next;
        p0y_reg         <= p0y_next;
        qx_reg          <= qx_next;
        qy_reg          <= qy_next;
        q_addr_reg      <= q_addr_next;
        walk_i_reg      <= walk_i_next;
        pend_id_reg     <= pend_id_next;
    end

endmodule

### rtl/hgnf_result_buf.sv
// ----------------------------------------------------------------------------
// hgnf_result_buf
// Output queue that holds every result word of one query, so the walk
// never has to stop for the downstream side.
// ----------------------------------------------------------------------------
module hgnf_result_buf #(
    parameter int DEPTH = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  hgnf_pkg::result_t  push_data,
    output logic               empty,
    output logic               out_valid,
    input  logic               out_stall,
    output hgnf_pkg::result_t  out_data
);

    import hgnf_pkg::*;

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    result_t         buf_q [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic            pop;

    assign empty     = (cnt_reg == '0);
    assign out_valid = !empty;
    assign out_data  = buf_q[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push_valid && !pop)
        begin
            cnt_next = cnt_reg + CNTW'(1);
        end
        else if (pop && !push_valid)
        begin
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            buf_q[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/hex_grid_neighbor_finder_top.sv
// ----------------------------------------------------------------------------
// hex_grid_neighbor_finder_top
// Neighbor finder for cell centers on a regular grid: loads points, tracks
// the grid spacing and lists the neighbors of a queried point.
// ----------------------------------------------------------------------------
// Commands enter a four-word input queue and run one at a time in the back
// end. A load writes the point memory and, from the second point on, runs
// the squared distance to the first point through a three-stage pipeline.
// A query first waits until the result queue has drained, then reads the
// queried point and walks every loaded point through the single read port
// of the point memory, one point a cycle. A bad query returns its single
// result. Each query gives one to MAX_NEIGHBORS result words, the final
// one marked last.
module hex_grid_neighbor_finder_top #(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 6,
    parameter int COORD_BITS    = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [hgnf_pkg::FUNC_BITS-1:0]      func,
    input  logic signed [COORD_BITS-1:0]        x_coord,
    input  logic signed [COORD_BITS-1:0]        y_coord,
    input  logic [hgnf_pkg::ID_BITS-1:0]        cell_id,
    input  logic [hgnf_pkg::QIDX_BITS-1:0]      query_index,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hgnf_pkg::ID_BITS-1:0]        neighbor_id,
    output logic                                found,
    output logic                                last,
    output logic                                overflow,
    output logic                                bad_query
);

    import hgnf_pkg::*;

    logic                  cmd_valid;
    logic                  cmd_pop;
    logic [FUNC_BITS-1:0]  cmd_func;
    logic signed [COORD_BITS-1:0] cmd_x;
    logic signed [COORD_BITS-1:0] cmd_y;
    logic [ID_BITS-1:0]    cmd_id;
    logic [QIDX_BITS-1:0]  cmd_qidx;
    logic                  res_empty;
    logic                  push_valid;
    result_t               push_data;
    result_t               out_data;

    hgnf_cmd_queue #(
        .COORD_BITS (COORD_BITS)
    ) u_cmd_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .cell_id     (cell_id),
        .query_index (query_index),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd_func    (cmd_func),
        .cmd_x       (cmd_x),
        .cmd_y       (cmd_y),
        .cmd_id      (cmd_id),
        .cmd_qidx    (cmd_qidx)
    );

    hgnf_walker #(
        .MAX_POINTS    (MAX_POINTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .COORD_BITS    (COORD_BITS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd_func   (cmd_func),
        .cmd_x      (cmd_x),
        .cmd_y      (cmd_y),
        .cmd_id     (cmd_id),
        .cmd_qidx   (cmd_qidx),
        .out_empty  (res_empty),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    hgnf_result_buf #(
        .DEPTH (MAX_NEIGHBORS)
    ) u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .empty      (res_empty),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    assign neighbor_id = out_data.neighbor_id;
    assign found       = out_data.found;
    assign last        = out_data.last;
    assign overflow    = out_data.overflow;
    assign bad_query   = out_data.bad_query;

endmodule

### verif/hex_grid_neighbor_finder_top_test.sv
// ----------------------------------------------------------------------------
// hex_grid_neighbor_finder_top_test
// Self-checking bench for the grid neighbor finder. Point sets are loaded
// and queried through the valid/stall channels. A built-in predictor tracks
// the stored points and the grid spacing, and it queues the neighbor words
// each query should return. Random idling on both sides and a long hold on
// the result side stress the flow control.
// ----------------------------------------------------------------------------
module hex_grid_neighbor_finder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hgnf_pkg::*;

    localparam int MAX_PTS        = 1024;
    localparam int MAX_NBR        = 6;
    localparam int COORD_W        = 24;
    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int END_SETTLE     = 64;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_REPORTS    = 100;
    localparam int ID_MAX         = (1 << ID_BITS) - 1;
    localparam int QIDX_MAX       = (1 << QIDX_BITS) - 1;
    localparam int COORD_MIN      = -(1 << (COORD_W - 1));
    localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
    localparam longint SPACING_INIT = (longint'(1) << (2 * COORD_W + 2)) - 1;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [FUNC_BITS-1:0]        func;
    logic signed [COORD_W-1:0]   x_coord;
    logic signed [COORD_W-1:0]   y_coord;
    logic [ID_BITS-1:0]          cell_id;
    logic [QIDX_BITS-1:0]        query_index;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [ID_BITS-1:0]          neighbor_id;
    logic                        found;
    logic                        last;
    logic                        overflow;
    logic                        bad_query;

    logic signed [COORD_W-1:0]   pt_x [MAX_PTS];
    logic signed [COORD_W-1:0]   pt_y [MAX_PTS];
    logic [ID_BITS-1:0]          pt_id [MAX_PTS];
    int                          loaded_count;
    longint                      spacing_sq;
    bit                          spacing_set;
    result_t                     pending_neighbors [$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;

    hex_grid_neighbor_finder_top #(
        .MAX_POINTS    (MAX_PTS),
        .MAX_NEIGHBORS (MAX_NBR),
        .COORD_BITS    (COORD_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .cell_id     (cell_id),
        .query_index (query_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .neighbor_id (neighbor_id),
        .found       (found),
        .last        (last),
        .overflow    (overflow),
        .bad_query   (bad_query)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic append_expected(input result_t w);
        pending_neighbors = {pending_neighbors, w};
    endtask

    function automatic longint sq_distance(input longint ax, input longint ay,
                                           input longint bx, input longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        if (dx < 0)
        begin
            dx = -dx;
        end
        if (dy < 0)
        begin
            dy = -dy;
        end
        return dx * dx + dy * dy;
    endfunction

    task automatic predict_neighbor_words(input logic [FUNC_BITS-1:0] f,
                                          input logic signed [COORD_W-1:0] px,
                                          input logic signed [COORD_W-1:0] py,
                                          input logic [ID_BITS-1:0] pid,
                                          input logic [QIDX_BITS-1:0] pq);
        longint  d;
        int      hits;
        result_t held;
        case (f)
            FUNC_LOAD:
            begin
                if (loaded_count < MAX_PTS)
                begin
                    pt_x[loaded_count]  = px;
                    pt_y[loaded_count]  = py;
                    pt_id[loaded_count] = pid;
                    if (loaded_count > 0)
                    begin
                        d = sq_distance(pt_x[0], pt_y[0], px, py);
                        if (d < spacing_sq)
                        begin
                            spacing_sq = d;
                        end
                        spacing_set = 1'b1;
                    end
                    loaded_count++;
                end
            end
            FUNC_CLEAR:
            begin
                loaded_count = 0;
                spacing_sq   = SPACING_INIT;
                spacing_set  = 1'b0;
            end
            FUNC_QUERY:
            begin
                if (loaded_count < 2 || !spacing_set || int'(pq) >= loaded_count)
                begin
                    append_expected('{'0, 1'b0, 1'b1, 1'b0, 1'b1});
                end
                else
                begin
                    hits = 0;
                    for (int i = 0; i < loaded_count; i++)
                    begin
                        if (i != int'(pq))
                        begin
                            d = sq_distance(pt_x[pq], pt_y[pq], pt_x[i], pt_y[i]);
                            if (4 * d < 9 * spacing_sq)
                            begin
                                if (hits > 0 && hits < MAX_NBR)
                                begin
                                    append_expected(held);
                                end
                                if (hits < MAX_NBR)
                                begin
                                    held = '{pt_id[i], 1'b1, 1'b0, 1'b0, 1'b0};
                                end
                                hits++;
                            end
                        end
                    end
                    if (hits == 0)
                    begin
                        append_expected('{'0, 1'b0, 1'b1, 1'b0, 1'b0});
                    end
                    else
                    begin
                        held.last     = 1'b1;
                        held.overflow = (hits > MAX_NBR);
                        append_expected(held);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // entered and left at a falling edge
    task automatic send_word(input logic [FUNC_BITS-1:0] f, input int xv, input int yv,
                             input int idv, input int qv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        x_coord     <= xv[COORD_W-1:0];
        y_coord     <= yv[COORD_W-1:0];
        cell_id     <= idv[ID_BITS-1:0];
        query_index <= qv[QIDX_BITS-1:0];
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_neighbor_words(func, x_coord, y_coord, cell_id, query_index);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_neighbors.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic test_bad_queries();
        send_word(FUNC_QUERY, 0, 0, 0, 0);
        send_word(FUNC_LOAD, 100, 200, 1, 0);
        send_word(FUNC_QUERY, 0, 0, 0, 0);
        send_word(FUNC_UNUSED, 3, 3, ID_MAX, QIDX_MAX);
        send_word(FUNC_QUERY, 0, 0, 0, QIDX_MAX);
    endtask

    task automatic test_coord_extremes();
        send_word(FUNC_CLEAR, 0, 0, 0, 0);
        send_word(FUNC_LOAD, COORD_MIN, COORD_MIN, 0, 0);
        send_word(FUNC_LOAD, COORD_MAX, COORD_MAX, ID_MAX, 0);
        send_word(FUNC_LOAD, COORD_MAX, COORD_MIN, 'h5A5A5, 0);
        send_word(FUNC_QUERY, 0, 0, 0, 0);
        send_word(FUNC_QUERY, 0, 0, 0, 3);
    endtask

    task automatic test_coincident_points();
        send_word(FUNC_CLEAR, 0, 0, 0, 0);
        send_word(FUNC_LOAD, 5, 5, 2, 0);
        send_word(FUNC_LOAD, 5, 5, 3, 0);
        send_word(FUNC_QUERY, 0, 0, 0, 1);
    endtask

    task automatic test_neighbor_overflow();
        send_word(FUNC_CLEAR, 0, 0, 0, 0);
        send_word(FUNC_LOAD, 0, 0, 10, 0);
        send_word(FUNC_LOAD, 10, 0, 11, 0);
        send_word(FUNC_LOAD, 0, 10, 12, 0);
        send_word(FUNC_LOAD, -10, 0, 13, 0);
        send_word(FUNC_LOAD, 0, -10, 14, 0);
        send_word(FUNC_LOAD, 7, 7, 15, 0);
        send_word(FUNC_LOAD, -7, 7, 16, 0);
        send_word(FUNC_LOAD, 7, -7, 17, 0);
        send_word(FUNC_QUERY, 0, 0, 0, 0);
    endtask

    task automatic test_random_sets(input int target);
        int done;
        int kind;
        int n;
        int rows;
        int cols;
        int s;
        int ox;
        int oy;
        int k;
        int idx;
        int nq;
        int q;
        int px;
        int py;
        int gx [$];
        int gy [$];
        done = 0;
        while (done < target)
        begin
            gx.delete();
            gy.delete();
            kind = $urandom_range(99);
            ox = $urandom_range(0, 16000000) + COORD_MIN;
            oy = $urandom_range(0, 16000000) + COORD_MIN;
            if (kind < 60)
            begin
                rows = $urandom_range(1, 6);
                cols = $urandom_range(1, 7);
                s = $urandom_range(1, 3000);
                for (int r = 0; r < rows; r++)
                begin
                    for (int c = 0; c < cols; c++)
                    begin
                        px = ox + 2 * c * s + ((r % 2) * s);
                        py = oy + 2 * r * s;
                        if ($urandom_range(99) < 15)
                        begin
                            px += $urandom_range(0, s / 2) - s / 4;
                        end
                        gx = {gx, px};
                        gy = {gy, py};
                    end
                end
            end
            else if (kind < 85)
            begin
                s = $urandom_range(1, 12);
                n = $urandom_range(2, 30);
                for (int i = 0; i < n; i++)
                begin
                    gx = {gx, ox + int'($urandom_range(0, s))};
                    gy = {gy, oy + int'($urandom_range(0, s))};
                end
            end
            else
            begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                begin
                    gx = {gx, int'($urandom)};
                    gy = {gy, int'($urandom)};
                end
            end
            n = gx.size();
            if ($urandom_range(99) < 90)
            begin
                send_word(FUNC_CLEAR, $urandom, $urandom, $urandom_range(0, ID_MAX),
                          $urandom_range(0, QIDX_MAX));
                done++;
            end
            k = (n > 0) ? $urandom_range(0, n - 1) : 0;
            for (int i = 0; i < n; i++)
            begin
                idx = (k + i) % n;
                if ($urandom_range(99) < 4)
                begin
                    send_word(FUNC_UNUSED, $urandom, $urandom, $urandom_range(0, ID_MAX),
                              $urandom_range(0, QIDX_MAX));
                end
                send_word(FUNC_LOAD, gx[idx], gy[idx], $urandom_range(0, ID_MAX),
                          $urandom_range(0, QIDX_MAX));
                done++;
                if ($urandom_range(99) < 6)
                begin
                    send_word(FUNC_QUERY, $urandom, $urandom, $urandom_range(0, ID_MAX),
                              $urandom_range(0, i));
                    done++;
                end
            end
            nq = $urandom_range(1, 6);
            for (int j = 0; j < nq; j++)
            begin
                if (n > 0 && $urandom_range(99) < 85)
                begin
                    q = $urandom_range(0, n - 1);
                end
                else
                begin
                    q = $urandom_range(0, QIDX_MAX);
                end
                send_word(FUNC_QUERY, $urandom, $urandom, $urandom_range(0, ID_MAX), q);
                done++;
            end
            if ($urandom_range(99) < 10)
            begin
                wait_results_drained();
            end
        end
    endtask

    // result side held off while queries keep coming, then a full drain
    task automatic test_result_backpressure();
        hold_request = LONG_HOLD;
        send_word(FUNC_CLEAR, 0, 0, 0, 0);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                send_word(FUNC_LOAD, 40 * c + 20 * (r % 2), 40 * r, 100 + 3 * r + c, 0);
            end
        end
        for (int j = 0; j < 10; j++)
        begin
            send_word(FUNC_QUERY, 0, 0, 0, j % 9);
        end
        wait_results_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_neighbors.size() == 0)
            begin
                report_error($sformatf("unexpected result word id %0h", neighbor_id));
            end
            else
            begin
                want = pending_neighbors.pop_front();
                if (neighbor_id !== want.neighbor_id)
                    report_error($sformatf("neighbor_id %0h, want %0h",
                                           neighbor_id, want.neighbor_id));
                if (found !== want.found)
                    report_error($sformatf("found %b, want %b", found, want.found));
                if (last !== want.last)
                    report_error($sformatf("last %b, want %b", last, want.last));
                if (overflow !== want.overflow)
                    report_error($sformatf("overflow %b, want %b", overflow, want.overflow));
                if (bad_query !== want.bad_query)
                    report_error($sformatf("bad_query %b, want %b",
                                           bad_query, want.bad_query));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_LOAD;
        x_coord      = '0;
        y_coord      = '0;
        cell_id      = '0;
        query_index  = '0;
        loaded_count = 0;
        spacing_sq   = SPACING_INIT;
        spacing_set  = 1'b0;
        error_count  = 0;
        hold_request = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        send_idle_pct = 19;
        recv_idle_pct = 55;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_bad_queries();
        test_coord_extremes();
        test_coincident_points();
        test_neighbor_overflow();
        test_random_sets(130);
        test_result_backpressure();

        send_idle_pct = 55;
        recv_idle_pct = 19;
        test_random_sets(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sets(120);

        wait_results_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (pending_neighbors.size() != 0)
        begin
            report_error($sformatf("%0d result words never arrived",
                                   pending_neighbors.size()));
        end
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
rtl/hgnf_pkg.sv
rtl/hgnf_cmd_queue.sv
rtl/hgnf_dist.sv
rtl/hgnf_walker.sv
rtl/hgnf_result_buf.sv
rtl/hex_grid_neighbor_finder_top.sv
verif/hex_grid_neighbor_finder_top_test.sv
